[design/arprf_pkg.sv]
package arprf_pkg;

    // frame byte position, saturating at the end of the fields of interest
    typedef logic [5:0] byte_pos_t;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;

    typedef logic [MAC_W-1:0] mac_addr_t;
    typedef logic [IP_W-1:0]  ip_addr_t;

    // result word, sender mac in the low bits
    typedef struct packed {
        ip_addr_t  sender_ip;
        mac_addr_t sender_mac;
    } reply_data_t;

    localparam byte_pos_t POS_DEST_END = 6'd6;
    localparam byte_pos_t POS_TYPE_HI  = 6'd12;
    localparam byte_pos_t POS_TYPE_LO  = 6'd13;
    localparam byte_pos_t POS_OPCODE   = 6'd21;
    localparam byte_pos_t POS_SHA_LO   = 6'd22;
    localparam byte_pos_t POS_SHA_HI   = 6'd27;
    localparam byte_pos_t POS_SPA_LO   = 6'd28;
    localparam byte_pos_t POS_SPA_HI   = 6'd31;
    localparam byte_pos_t POS_MAX      = 6'd32;

    localparam logic [7:0] ETHERTYPE_ARP_HI = 8'h08;
    localparam logic [7:0] ETHERTYPE_ARP_LO = 8'h06;
    localparam logic [7:0] ARP_OP_REPLY     = 8'h02;

endpackage

[design/arp_reply_frame_filter.sv]
// channel | dir | width          | contents (lowest bit first)
// s_      | in  | tdata 8, tlast | data_byte; tlast = frame_last
// m_      | out | tdata 80, tuser| sender_mac, sender_ip; tuser = reply_valid
// cfg_    | in  | wdata 48       | own_mac, written when cfg_we is high
//
// one byte is taken every cycle that s_tready is high; the frame state is updated at the accepting edge
// a frame's result appears on m_ in the cycle after its last byte is taken
// the single output register allows a new word in the cycle that the result is taken
// s_tready drops only while a result waits and m_tready is low
// aresetn is synchronous and active low; it clears own_mac and all frame state
module arp_reply_frame_filter (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         s_tlast,     // frame_last

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,     // [47:0] sender_mac, [79:48] sender_ip
    output logic         m_tuser,     // reply_valid

    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata    // own_mac, byte 0 of the frame in [47:40]
);

    // configuration
    arprf_pkg::mac_addr_t   own_mac_reg;

    // frame state
    arprf_pkg::byte_pos_t   byte_count_reg, byte_count_next;
    logic                   dest_match_reg, dest_match_next;
    logic                   type_match_reg, type_match_next;
    logic                   opcode_match_reg, opcode_match_next;
    arprf_pkg::mac_addr_t   captured_mac_reg, captured_mac_next;
    arprf_pkg::ip_addr_t    captured_ip_reg, captured_ip_next;

    // result register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   reply_valid_reg, reply_valid_next;
    arprf_pkg::reply_data_t reply_data_reg, reply_data_next;

    logic                   s_accept;
    logic [7:0]             want_byte;
    logic                   reply_ok;

    // a byte may come in whenever the result slot is free or being emptied
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // destination byte expected at this position, byte 0 is the top of own_mac
    assign want_byte = own_mac_reg[{3'd5 - byte_count_reg[2:0], 3'b000} +: 8];

    always_comb begin
        byte_count_next   = byte_count_reg;
        dest_match_next   = dest_match_reg;
        type_match_next   = type_match_reg;
        opcode_match_next = opcode_match_reg;
        captured_mac_next = captured_mac_reg;
        captured_ip_next  = captured_ip_reg;

        if (byte_count_reg < arprf_pkg::POS_DEST_END) begin
            // destination address
            if (s_tdata != want_byte) begin
                dest_match_next = 1'b0;
            end
        end else if (byte_count_reg == arprf_pkg::POS_TYPE_HI) begin
            if (s_tdata != arprf_pkg::ETHERTYPE_ARP_HI) begin
                type_match_next = 1'b0;
            end
        end else if (byte_count_reg == arprf_pkg::POS_TYPE_LO) begin
            if (s_tdata != arprf_pkg::ETHERTYPE_ARP_LO) begin
                type_match_next = 1'b0;
            end
        end else if (byte_count_reg == arprf_pkg::POS_OPCODE) begin
            // only the low opcode byte is looked at
            opcode_match_next = (s_tdata == arprf_pkg::ARP_OP_REPLY);
        end else if (byte_count_reg >= arprf_pkg::POS_SHA_LO &&
                     byte_count_reg <= arprf_pkg::POS_SHA_HI) begin
            captured_mac_next = {captured_mac_reg[arprf_pkg::MAC_W-9:0], s_tdata};
        end else if (byte_count_reg >= arprf_pkg::POS_SPA_LO &&
                     byte_count_reg <= arprf_pkg::POS_SPA_HI) begin
            captured_ip_next = {captured_ip_reg[arprf_pkg::IP_W-9:0], s_tdata};
        end

        // saturate once the sender ip has gone past
        if (byte_count_reg < arprf_pkg::POS_MAX) begin
            byte_count_next = byte_count_reg + 6'd1;
        end
    end

    // verdict from the state including the byte just taken
    assign reply_ok = dest_match_next && type_match_next && opcode_match_next &&
                      (byte_count_next >= arprf_pkg::POS_MAX);

    always_comb begin
        m_tvalid_next    = m_tvalid_reg;
        reply_valid_next = reply_valid_reg;
        reply_data_next  = reply_data_reg;
        if (s_accept && s_tlast) begin
            m_tvalid_next              = 1'b1;
            reply_valid_next           = reply_ok;
            reply_data_next.sender_mac = reply_ok ? captured_mac_next : '0;
            reply_data_next.sender_ip  = reply_ok ? captured_ip_next : '0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
        end else if (cfg_we) begin
            own_mac_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            dest_match_reg   <= 1'b1;
            type_match_reg   <= 1'b1;
            opcode_match_reg <= 1'b0;
            captured_mac_reg <= '0;
            captured_ip_reg  <= '0;
        end else if (s_accept) begin
            if (s_tlast) begin
                // back to the start of a frame
                byte_count_reg   <= '0;
                dest_match_reg   <= 1'b1;
                type_match_reg   <= 1'b1;
                opcode_match_reg <= 1'b0;
                captured_mac_reg <= '0;
                captured_ip_reg  <= '0;
            end else begin
                byte_count_reg   <= byte_count_next;
                dest_match_reg   <= dest_match_next;
                type_match_reg   <= type_match_next;
                opcode_match_reg <= opcode_match_next;
                captured_mac_reg <= captured_mac_next;
                captured_ip_reg  <= captured_ip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only with a last byte
    always_ff @(posedge aclk) begin
        reply_valid_reg <= reply_valid_next;
        reply_data_reg  <= reply_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = reply_valid_reg;
    assign m_tdata  = reply_data_reg;

    // count never runs past its saturation point
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= arprf_pkg::POS_MAX)
        else $error("byte count beyond saturation");

    // a last byte always leaves a result and a fresh frame state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (m_tvalid && byte_count_reg == '0 &&
                                   dest_match_reg && type_match_reg && !opcode_match_reg))
        else $error("frame end not handled");

    // a rejected frame carries no addresses
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("addresses on a rejected frame");

    // a reply is flagged only for a frame that reached the sender ip
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast && byte_count_reg < arprf_pkg::POS_SPA_HI) |=> !m_tuser)
        else $error("short frame accepted as reply");

    // the input is never held off while the result slot is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty result slot");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    // ethertype that marks an arp frame, both bytes together
    localparam logic [15:0] ARP_ETYPE = {arprf_pkg::ETHERTYPE_ARP_HI,
                                         arprf_pkg::ETHERTYPE_ARP_LO};
    // run is cut off here; the slowest correct run needs a small fraction of it
    localparam int CYCLE_LIMIT = 200000;
    // random traffic per idling phase, in accepted words
    localparam int PHASE_BYTES = 410;

    // one filter verdict as the block should report it
    typedef struct packed {
        logic                 valid;
        arprf_pkg::mac_addr_t mac;
        arprf_pkg::ip_addr_t  ip;
    } arp_reply_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;       // [7:0] data_byte
    logic         s_tlast = 1'b0;     // frame_last

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;            // [47:0] sender_mac, [79:48] sender_ip
    logic         m_tuser;            // reply_valid

    logic         cfg_we = 1'b0;
    logic [47:0]  cfg_wdata = '0;     // own_mac

    // idling odds for each side, in percent of cycles
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // long receiver hold-off, counted down by the ready process
    int rx_hold_left = 0;

    int bytes_sent = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // station address as last written, used to build addressed frames
    arprf_pkg::mac_addr_t station_mac = '0;
    // frame under construction, byte 0 first
    logic [7:0] frame_buf[$];

    // filter state as the predictor tracks it
    arprf_pkg::mac_addr_t trk_own_mac;
    arprf_pkg::byte_pos_t trk_pos;
    logic                 trk_dest_ok;
    logic                 trk_type_ok;
    logic                 trk_op_ok;
    arprf_pkg::mac_addr_t trk_sha;
    arprf_pkg::ip_addr_t  trk_spa;

    // verdicts owed by the block, oldest first
    arp_reply_t pending_replies[$];

    arp_reply_frame_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // frame state back to its start-of-frame values
    task clear_tracked_frame();
        trk_pos     = '0;
        trk_dest_ok = 1'b1;
        trk_type_ok = 1'b1;
        trk_op_ok   = 1'b0;
        trk_sha     = '0;
        trk_spa     = '0;
    endtask

    // advance the tracked filter by one accepted word; a last byte owes a verdict
    task track_frame_byte(input logic [7:0] data, input logic is_last);
        int         p;
        arp_reply_t verdict;
        p = int'(trk_pos);
        if (trk_pos < arprf_pkg::POS_DEST_END) begin
            // destination compared against the station address byte by byte
            if (data != trk_own_mac[47 - 8*p -: 8])
                trk_dest_ok = 1'b0;
        end else if (trk_pos == arprf_pkg::POS_TYPE_HI) begin
            if (data != arprf_pkg::ETHERTYPE_ARP_HI)
                trk_type_ok = 1'b0;
        end else if (trk_pos == arprf_pkg::POS_TYPE_LO) begin
            if (data != arprf_pkg::ETHERTYPE_ARP_LO)
                trk_type_ok = 1'b0;
        end else if (trk_pos == arprf_pkg::POS_OPCODE) begin
            // only the low opcode byte counts
            trk_op_ok = (data == arprf_pkg::ARP_OP_REPLY);
        end else if (trk_pos >= arprf_pkg::POS_SHA_LO && trk_pos <= arprf_pkg::POS_SHA_HI) begin
            trk_sha = {trk_sha[39:0], data};
        end else if (trk_pos >= arprf_pkg::POS_SPA_LO && trk_pos <= arprf_pkg::POS_SPA_HI) begin
            trk_spa = {trk_spa[23:0], data};
        end
        // count saturates, so long frames stay at the top
        if (trk_pos < arprf_pkg::POS_MAX)
            trk_pos = trk_pos + 1'b1;
        if (is_last) begin
            verdict.valid = trk_dest_ok && trk_type_ok && trk_op_ok &&
                            (trk_pos >= arprf_pkg::POS_MAX);
            verdict.mac   = verdict.valid ? trk_sha : '0;
            verdict.ip    = verdict.valid ? trk_spa : '0;
            pending_replies = {pending_replies, verdict};
            clear_tracked_frame();
        end
    endtask

    // watches every handshake at the clock edge: writes, input words, result words
    always @(posedge aclk) begin
        arprf_pkg::reply_data_t got;
        arp_reply_t             want;
        if (!aresetn) begin
            trk_own_mac = '0;
            clear_tracked_frame();
            pending_replies.delete();
        end else begin
            if (cfg_we)
                trk_own_mac = cfg_wdata;
            if (s_tvalid && s_tready)
                track_frame_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_replies.size() == 0) begin
                    $error("result word with nothing expected: valid %0b mac %h ip %h",
                           m_tuser, got.sender_mac, got.sender_ip);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tuser !== want.valid) begin
                        $error("reply_valid: expected %0b, got %0b", want.valid, m_tuser);
                        fail_count++;
                    end
                    if (got.sender_mac !== want.mac) begin
                        $error("sender_mac: expected %h, got %h", want.mac, got.sender_mac);
                        fail_count++;
                    end
                    if (got.sender_ip !== want.ip) begin
                        $error("sender_ip: expected %h, got %h", want.ip, got.sender_ip);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic arprf_pkg::mac_addr_t rand_mac();
        return arprf_pkg::mac_addr_t'({$urandom, $urandom});
    endfunction

    // offer one word and hold it until the block takes it
    task send_byte(input logic [7:0] data, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // send the frame buffer with tlast on its final byte
    task send_frame();
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // arp layout over ethernet; bytes outside the given fields are random, frame cut at len
    task send_arp_frame(input int len, input arprf_pkg::mac_addr_t dest,
                        input logic [15:0] etype,
                        input logic [7:0] op_hi, input logic [7:0] op_lo,
                        input arprf_pkg::mac_addr_t sha, input arprf_pkg::ip_addr_t spa);
        int         i;
        logic [7:0] b;
        frame_buf.delete();
        for (i = 0; i < len; i++) begin
            if (i < 6)
                b = dest[47 - 8*i -: 8];
            else if (i == 12)
                b = etype[15:8];
            else if (i == 13)
                b = etype[7:0];
            else if (i == 20)
                b = op_hi;
            else if (i == 21)
                b = op_lo;
            else if (i >= 22 && i <= 27)
                b = sha[47 - 8*(i - 22) -: 8];
            else if (i >= 28 && i <= 31)
                b = spa[31 - 8*(i - 28) -: 8];
            else
                b = 8'($urandom);
            frame_buf = {frame_buf, b};
        end
        send_frame();
    endtask

    // stop offering and let every owed result come out
    task wait_for_replies();
        s_tvalid <= 1'b0;
        // let the current edge pass first so that a word taken at it is already tracked
        @(posedge aclk);
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    // station address write, only with the block idle
    task write_own_mac(input arprf_pkg::mac_addr_t mac);
        wait_for_replies();
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mac;
        @(posedge aclk);
        cfg_we <= 1'b0;
        station_mac = mac;
    endtask

    // station address is zero out of reset; sender fields at both extremes
    task test_reset_station();
        send_arp_frame(32, '0, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY, '1, '1);
        // opcode high byte is never looked at
        send_arp_frame(32, '0, ARP_ETYPE, 8'hFF, arprf_pkg::ARP_OP_REPLY, '0, '0);
    endtask

    // short frames are refused, long ones pass with the tail ignored
    task test_frame_length();
        send_arp_frame(31, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(1, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        // frame state must be clean again after the one-word frame
        send_arp_frame(32, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(70, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(33, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
    endtask

    // each header check on its own
    task test_header_fields();
        send_arp_frame(32, station_mac, 16'h0800, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(32, station_mac, 16'h0906, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(32, station_mac, ARP_ETYPE, 8'h00, 8'h01, rand_mac(), $urandom);
        send_arp_frame(32, station_mac, ARP_ETYPE, 8'h00, 8'hFF, rand_mac(), $urandom);
        // mismatch in the first and in the last destination byte
        send_arp_frame(32, station_mac ^ 48'h8000_0000_0000, ARP_ETYPE, 8'h00,
                       arprf_pkg::ARP_OP_REPLY, rand_mac(), $urandom);
        send_arp_frame(32, station_mac ^ 48'h0000_0000_0001, ARP_ETYPE, 8'h00,
                       arprf_pkg::ARP_OP_REPLY, rand_mac(), $urandom);
    endtask

    // station address all ones, an alternating pattern and a random value
    task test_station_mac();
        write_own_mac('1);
        send_arp_frame(32, '1, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        send_arp_frame(32, '0, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        write_own_mac(48'hAAAA_5555_AAAA);
        send_arp_frame(32, 48'hAAAA_5555_AAAA, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
        write_own_mac(rand_mac());
        send_arp_frame(40, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                       rand_mac(), $urandom);
    endtask

    // receiver holds off while short frames keep coming, so the input must stall
    task test_output_stall();
        int i;
        wait_for_replies();
        rx_hold_left = 300;
        for (i = 0; i < 10; i++) begin
            if (i % 3 == 2)
                send_arp_frame(32, station_mac, ARP_ETYPE, 8'h00, arprf_pkg::ARP_OP_REPLY,
                               rand_mac(), $urandom);
            else
                send_arp_frame($urandom_range(3, 1), station_mac, ARP_ETYPE, 8'h00,
                               arprf_pkg::ARP_OP_REPLY, rand_mac(), $urandom);
        end
        wait_for_replies();
    endtask

    // mostly well-formed replies with random content, plus broken and noise frames
    task send_random_frame();
        int                   kind;
        int                   len;
        int                   i;
        int                   bit_sel;
        arprf_pkg::mac_addr_t dest;
        logic [15:0]          etype;
        logic [7:0]           op_lo;
        kind  = $urandom_range(99);
        len   = ($urandom_range(19) == 0) ? $urandom_range(80, 41) : $urandom_range(40, 32);
        dest  = station_mac;
        etype = ARP_ETYPE;
        op_lo = arprf_pkg::ARP_OP_REPLY;
        if (kind < 10) begin
            // plain noise
            frame_buf.delete();
            len = $urandom_range(48, 1);
            for (i = 0; i < len; i++)
                frame_buf = {frame_buf, 8'($urandom)};
            send_frame();
        end else begin
            if (kind < 20) begin
                len = $urandom_range(31, 1);
            end else if (kind < 27) begin
                bit_sel = $urandom_range(47);
                dest[bit_sel] = ~dest[bit_sel];
            end else if (kind < 32) begin
                bit_sel = $urandom_range(15);
                etype[bit_sel] = ~etype[bit_sel];
            end else if (kind < 37) begin
                op_lo = 8'($urandom);
            end
            send_arp_frame(len, dest, etype, 8'($urandom), op_lo, rand_mac(), $urandom);
        end
    endtask

    // three idling phases, each with its own station address
    task test_random_traffic();
        int target;
        int phase;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 74;
                end
                1: begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 12;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_own_mac(rand_mac());
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_frame();
        end
    endtask

    initial begin
        // synchronous reset held low from the start, then released
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 12;
        rx_idle_pct = 74;
        test_reset_station();
        test_frame_length();
        test_header_fields();
        test_station_mac();
        test_output_stall();
        test_random_traffic();

        // drain, then wait on for anything stray
        wait_for_replies();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[arp_reply_frame_filter.f]
design/arprf_pkg.sv
design/arp_reply_frame_filter.sv
dv/testbench.sv
